FILE: design/lfc_pkg.sv
// ---------------------------------------------------------------------------
// lfc_pkg : shared types and codes of the log frame checker
// Result beat layout, queue entry, configuration set and status codes.
// ---------------------------------------------------------------------------
package lfc_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

   // result kinds
   localparam logic [1:0] KIND_ID      = 2'd0;
   localparam logic [1:0] KIND_VECTOR  = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   // verdict status codes
   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_BADLEN  = 4'd1;
   localparam logic [3:0] ST_TORN    = 4'd2;
   localparam logic [3:0] ST_CRC     = 4'd3;
   localparam logic [3:0] ST_OP      = 4'd4;
   localparam logic [3:0] ST_OVERRUN = 4'd5;
   localparam logic [3:0] ST_REMOVE  = 4'd6;
   localparam logic [3:0] ST_PARTIAL = 4'd7;
   localparam logic [3:0] ST_CLEAN   = 4'd8;

   // register indexes
   localparam logic [1:0] REG_INSERT = 2'd0;
   localparam logic [1:0] REG_REMOVE = 2'd1;
   localparam logic [1:0] REG_BULK   = 2'd2;
   localparam logic [1:0] REG_MAXPAY = 2'd3;

   typedef struct packed {
      logic [7:0]  insert_code;
      logic [7:0]  remove_code;
      logic [7:0]  bulk_code;
      logic [31:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] word;
      logic [7:0]  record_op;
      logic [31:0] id_count;
      logic [29:0] vector_words;
      logic [3:0]  status;
   } result_type;

   // an entry holds the one or two results of one accepted byte
   typedef struct packed {
      result_type r0;
      result_type r1;
      logic       two;
   } entry_type;

endpackage

FILE: design/lfc_front.sv
// ---------------------------------------------------------------------------
// lfc_front : byte parser of the log frame checker
// Tracks header/payload, assembles words, runs the CRC and builds result
// entries for the queue, one accepted byte per cycle.
// ---------------------------------------------------------------------------
module lfc_front import lfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        accept,
   input  logic        action,
   input  logic [7:0]  data_byte,
   output logic        push,
   output entry_type   push_entry
);

   localparam logic PH_HEADER  = 1'b0;
   localparam logic PH_PAYLOAD = 1'b1;

   logic        phase_ff, phase_in;
   logic [31:0] index_ff, index_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] scrc_ff, scrc_in;
   logic [31:0] rcrc_ff, rcrc_in;
   logic [7:0]  op_ff, op_in;
   logic [31:0] count_ff, count_in;
   logic [63:0] asm_ff, asm_in;
   logic        halted_ff, halted_in;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
      end
      return x;
   endfunction

   function automatic logic [63:0] lane_in(input logic [63:0] a, input logic [2:0] lane,
                                           input logic [7:0] b);
      logic [63:0] base;
      base = (lane == 3'd0) ? 64'd0 : a;
      return base | ({56'd0, b} << {lane, 3'b000});
   endfunction

   logic [34:0] rel, idb, vrel;
   logic [35:0] ovr_need, vec_len;
   logic [31:0] crc_nx;
   logic [2:0]  lane;
   result_type  elem, verd;
   logic        have_elem, have_verd;
   logic [3:0]  vst;
   logic [29:0] vvw;

   // frame parsing and result generation
   always_comb begin
      phase_in  = phase_ff;
      index_in  = index_ff;
      length_in = length_ff;
      scrc_in   = scrc_ff;
      rcrc_in   = rcrc_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      asm_in    = asm_ff;
      halted_in = halted_ff;
      have_elem = 1'b0;
      have_verd = 1'b0;
      elem      = '0;
      verd      = '0;
      verd.kind = KIND_VERDICT;
      crc_nx    = crc_byte(rcrc_ff, data_byte);
      rel       = {3'd0, index_ff} - 35'd8;
      idb       = {count_ff, 3'b000};
      vrel      = rel - idb;
      lane      = 3'd0;
      vst       = ST_OK;
      vvw       = '0;
      ovr_need  = '0;
      vec_len   = '0;
      if (accept && !halted_ff) begin
         if (action) begin
            // end of log
            have_verd = 1'b1;
            halted_in = 1'b1;
            if (phase_ff == PH_HEADER) begin
               verd.status = (index_ff == 32'd0) ? ST_CLEAN : ST_TORN;
            end else begin
               verd.status    = ST_TORN;
               verd.record_op = op_ff;
               verd.id_count  = count_ff;
            end
         end else if (phase_ff == PH_HEADER) begin
            asm_in = lane_in(asm_ff, index_ff[2:0], data_byte);
            if (index_ff[2:0] == 3'd7) begin
               length_in = asm_in[31:0];
               scrc_in   = asm_in[63:32];
               index_in  = '0;
               if (asm_in[31:0] < 32'd8 || asm_in[31:0] > cfg.max_payload) begin
                  have_verd   = 1'b1;
                  verd.status = ST_BADLEN;
                  halted_in   = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
                  rcrc_in  = ALL_ONES;
                  op_in    = '0;
                  count_in = '0;
               end
            end else begin
               index_in = {29'd0, index_ff[2:0] + 3'd1};
            end
         end else begin
            rcrc_in = crc_nx;
            if (index_ff == 32'd0) begin
               op_in = data_byte;
            end else if (index_ff >= 32'd4 && index_ff <= 32'd7) begin
               asm_in = lane_in(asm_ff, {1'b0, index_ff[1:0]}, data_byte);
               if (index_ff == 32'd7) begin
                  count_in = asm_in[31:0];
               end
            end else if (index_ff >= 32'd8) begin
               if (rel < idb) begin
                  lane   = rel[2:0];
                  asm_in = lane_in(asm_ff, lane, data_byte);
                  if (lane == 3'd7) begin
                     have_elem = 1'b1;
                     elem.kind = KIND_ID;
                     elem.word = asm_in;
                  end
               end else begin
                  lane   = {1'b0, vrel[1:0]};
                  asm_in = lane_in(asm_ff, lane, data_byte);
                  if (lane == 3'd3) begin
                     have_elem         = 1'b1;
                     elem.kind         = KIND_VECTOR;
                     elem.word         = {32'd0, asm_in[31:0]};
                     elem.vector_words = vrel[31:2] + 30'd1;
                  end
               end
               elem.record_op = op_ff;
               elem.id_count  = count_ff;
            end
            // last payload byte: verdict in check order
            if ({1'b0, index_ff} + 33'd1 >= {1'b0, length_ff}) begin
               have_verd = 1'b1;
               phase_in  = PH_HEADER;
               index_in  = '0;
               ovr_need  = {1'b0, count_in, 3'b000} + 36'd8;
               vec_len   = {4'd0, length_ff} - ovr_need;
               if ((crc_nx ^ ALL_ONES) != scrc_ff) begin
                  vst = ST_CRC;
               end else if (op_in != cfg.insert_code && op_in != cfg.remove_code &&
                            op_in != cfg.bulk_code) begin
                  vst = ST_OP;
               end else if (ovr_need > {4'd0, length_ff}) begin
                  vst = ST_OVERRUN;
               end else if (op_in == cfg.remove_code) begin
                  if (count_in != 32'd1 || vec_len != 36'd0) begin
                     vst = ST_REMOVE;
                  end
               end else if (vec_len[1:0] != 2'd0) begin
                  vst = ST_PARTIAL;
               end
               if (vst == ST_OK) begin
                  vvw = vec_len[31:2];
               end else begin
                  halted_in = 1'b1;
               end
               verd.status       = vst;
               verd.vector_words = vvw;
               verd.record_op    = op_in;
               verd.id_count     = count_in;
            end else begin
               index_in = index_ff + 32'd1;
            end
         end
      end
   end

   // queue entry: element first, then verdict
   always_comb begin
      push           = have_elem || have_verd;
      push_entry.two = have_elem && have_verd;
      push_entry.r0  = have_elem ? elem : verd;
      push_entry.r1  = verd;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         index_ff  <= '0;
         length_ff <= '0;
         scrc_ff   <= '0;
         rcrc_ff   <= ALL_ONES;
         op_ff     <= '0;
         count_ff  <= '0;
         asm_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         index_ff  <= index_in;
         length_ff <= length_in;
         scrc_ff   <= scrc_in;
         rcrc_ff   <= rcrc_in;
         op_ff     <= op_in;
         count_ff  <= count_in;
         asm_ff    <= asm_in;
         halted_ff <= halted_in;
      end
   end

endmodule

FILE: design/lfc_queue.sv
// ---------------------------------------------------------------------------
// lfc_queue : entry queue between parser and output stage
// Small register FIFO of result entries; full drives the input stall.
// ---------------------------------------------------------------------------
module lfc_queue import lfc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      not_empty,
   output logic      full
);

   entry_type         store_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   // pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   assign head      = store_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == QCNT_W'(QDEPTH));

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH)) else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("pop from empty queue");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ff == rd_ff)) else $error("pointers differ when empty");

endmodule

FILE: design/lfc_back.sv
// ---------------------------------------------------------------------------
// lfc_back : output stage of the log frame checker
// Holds one entry and presents its results as one or two beats.
// ---------------------------------------------------------------------------
module lfc_back import lfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       not_empty,
   output logic       pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_res,
   output logic       rsp_last
);

   entry_type ent_ff, ent_in;
   logic      valid_ff, valid_in;
   logic      sel_ff, sel_in;
   logic      take, need_load;

   // beat sequencing
   always_comb begin
      take      = valid_ff && !rsp_stall;
      need_load = !valid_ff || (take && (sel_ff || !ent_ff.two));
      pop       = need_load && not_empty;
      ent_in    = ent_ff;
      valid_in  = valid_ff;
      sel_in    = sel_ff;
      if (need_load) begin
         ent_in   = head;
         valid_in = not_empty;
         sel_in   = 1'b0;
      end else if (take) begin
         sel_in = 1'b1;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = sel_ff ? ent_ff.r1 : ent_ff.r0;
   assign rsp_last  = sel_ff || !ent_ff.two;

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

FILE: design/log_frame_checker_core.sv
// ---------------------------------------------------------------------------
// log_frame_checker_core : length/CRC framed log checker
// Parses a byte-serial log and emits ids, vector words and frame verdicts.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per log byte (req_action 0) or end of log
//   (req_action 1). A beat is taken when req_valid is high and req_stall low.
//   rsp_ channel: id, vector word and verdict beats; rsp_last marks the
//   final beat caused by one input beat.
//   csr_ port (APB): insert, remove, bulk codes and max payload at 0,4,8,12.
// Throughput: one input beat per cycle unless req_stall; the parser handles a
// byte in the cycle it is taken. A byte closing both an element and a frame
// gives two beats, drained one per cycle by the output stage unless rsp_stall.
// Path: with the queue empty, a result reaches rsp_ through the queue write
// and then the output register after the edge that takes its input beat.
// Stall: a four-entry queue decouples parser and output; req_stall rises
// when it is full, so receiver stalls back up to the input.
// Reset: synchronous; clears parser state, queue and registers to defaults.
// After a failing verdict or end of log no further results until reset.
// ---------------------------------------------------------------------------
module log_frame_checker_core import lfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [63:0] rsp_word,
   output logic [7:0]  rsp_record_op,
   output logic [31:0] rsp_id_count,
   output logic [29:0] rsp_vector_words,
   output logic [3:0]  rsp_status,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       accept, push, pop, not_empty, full;
   entry_type  push_entry, head;
   result_type res;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_INSERT: cfg_in.insert_code = pwdata[7:0];
            REG_REMOVE: cfg_in.remove_code = pwdata[7:0];
            REG_BULK:   cfg_in.bulk_code   = pwdata[7:0];
            REG_MAXPAY: cfg_in.max_payload = pwdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_INSERT: prdata = {24'd0, cfg_ff.insert_code};
         REG_REMOVE: prdata = {24'd0, cfg_ff.remove_code};
         REG_BULK:   prdata = {24'd0, cfg_ff.bulk_code};
         REG_MAXPAY: prdata = cfg_ff.max_payload;
         default:    prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.insert_code <= 8'd1;
         cfg_ff.remove_code <= 8'd2;
         cfg_ff.bulk_code   <= 8'd3;
         cfg_ff.max_payload <= 32'h4000_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // beat acceptance
   assign req_stall = full;
   assign accept    = req_valid && !full;

   lfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .action     (req_action),
      .data_byte  (req_data_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   lfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .full       (full)
   );

   lfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_res   (res),
      .rsp_last  (rsp_last)
   );

   assign rsp_kind         = res.kind;
   assign rsp_word         = res.word;
   assign rsp_record_op    = res.record_op;
   assign rsp_id_count     = res.id_count;
   assign rsp_vector_words = res.vector_words;
   assign rsp_status       = res.status;

endmodule

FILE: verif/log_frame_checker_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// log_frame_checker_checker : result predictor and scoreboard
// Watches accepted log beats, rebuilds the expected id, vector and verdict
// beats from its own copy of parser state and registers, and compares every
// accepted result beat field by field against the oldest expectation.
// ---------------------------------------------------------------------------
module log_frame_checker_checker import lfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [63:0] rsp_word,
   input  logic [7:0]  rsp_record_op,
   input  logic [31:0] rsp_id_count,
   input  logic [29:0] rsp_vector_words,
   input  logic [3:0]  rsp_status,
   input  logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          pending_beats
);

   typedef struct {
      result_type r;
      logic       lst;
   } beat_type;

   beat_type   expected_beats[$];
   cfg_type    regs;
   logic       in_payload, stopped;
   logic [31:0] offset, flen, crc_stored, crc_run, count;
   logic [7:0]  op;
   logic [63:0] asm_word;

   function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
      c ^= {24'd0, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      return c;
   endfunction

   task automatic push_beat(logic [1:0] kd, logic [63:0] w, logic [29:0] vw,
                            logic [3:0] st);
      beat_type b;
      b.r.kind = kd;
      b.r.word = w;
      b.r.record_op = (kd == KIND_VERDICT && !in_payload) ? 8'd0 : op;
      b.r.id_count = (kd == KIND_VERDICT && !in_payload) ? 32'd0 : count;
      b.r.vector_words = vw;
      b.r.status = st;
      b.lst = 1'b0;
      expected_beats.push_back(b);
   endtask

   task automatic put_lane(int lane, logic [7:0] b);
      if (lane == 0) asm_word = '0;
      asm_word |= 64'(b) << (8 * lane);
   endtask

   // frame-end checks, in order: crc, op, id overrun, remove shape, whole words
   task automatic close_frame();
      logic [63:0] idb, vb;
      logic [3:0]  st;
      logic [29:0] vw;
      idb = 64'(count) * 8;
      vw = '0;
      if ((crc_run ^ ALL_ONES) != crc_stored) st = ST_CRC;
      else if (op != regs.insert_code && op != regs.remove_code &&
               op != regs.bulk_code) st = ST_OP;
      else if (64'd8 + idb > 64'(flen)) st = ST_OVERRUN;
      else begin
         vb = 64'(flen) - 8 - idb;
         st = ST_OK;
         if (op == regs.remove_code) begin
            if (count != 1 || vb != 0) st = ST_REMOVE;
         end else if (vb[1:0] != 0) st = ST_PARTIAL;
         if (st == ST_OK) vw = vb[31:2];
      end
      push_beat(KIND_VERDICT, '0, vw, st);
      in_payload = 1'b0;
      offset = 0;
      if (st != ST_OK) stopped = 1'b1;
   endtask

   task automatic predict_beat(logic act, logic [7:0] b);
      int n0;
      logic [63:0] rel, idb, v;
      n0 = expected_beats.size();
      if (stopped) return;
      if (act) begin
         push_beat(KIND_VERDICT, '0, '0,
                   (!in_payload && offset == 0) ? ST_CLEAN : ST_TORN);
         stopped = 1'b1;
      end else if (!in_payload) begin
         put_lane(offset[2:0], b);
         if (offset[2:0] == 3'd7) begin
            flen = asm_word[31:0];
            crc_stored = asm_word[63:32];
            offset = 0;
            if (flen < 8 || flen > regs.max_payload) begin
               push_beat(KIND_VERDICT, '0, '0, ST_BADLEN);
               stopped = 1'b1;
            end else begin
               in_payload = 1'b1;
               crc_run = ALL_ONES;
               op = '0;
               count = '0;
            end
         end else offset = offset + 1;
      end else begin
         crc_run = crc_update(crc_run, b);
         if (offset == 0) op = b;
         else if (offset >= 4 && offset <= 7) begin
            put_lane(offset - 4, b);
            if (offset == 7) count = asm_word[31:0];
         end else if (offset >= 8) begin
            rel = 64'(offset) - 8;
            idb = 64'(count) * 8;
            if (rel < idb) begin
               put_lane(rel[2:0], b);
               if (rel[2:0] == 3'd7) push_beat(KIND_ID, asm_word, '0, ST_OK);
            end else begin
               v = rel - idb;
               put_lane(v[1:0], b);
               if (v[1:0] == 2'd3)
                  push_beat(KIND_VECTOR, {32'd0, asm_word[31:0]},
                            30'(v[63:2] + 1), ST_OK);
            end
         end
         if (64'(offset) + 1 >= 64'(flen)) close_frame();
         else offset = offset + 1;
      end
      if (expected_beats.size() > n0)
         expected_beats[expected_beats.size() - 1].lst = 1'b1;
   endtask

   task automatic report(string what, logic [63:0] e, logic [63:0] a);
      if (fail_count < 10)
         $display("mismatch %s: expected %h actual %h at %0t", what, e, a, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      beat_type e;
      if (reset) begin
         regs = '{insert_code: 8'd1, remove_code: 8'd2, bulk_code: 8'd3,
                  max_payload: 32'h4000_0000};
         in_payload = 0; stopped = 0; offset = 0; flen = 0; crc_stored = 0;
         crc_run = ALL_ONES; op = 0; count = 0; asm_word = 0;
         expected_beats.delete();
         fail_count = 0;
      end else begin
         // register writes
         if (psel && penable && pwrite) begin
            case (paddr[3:2])
               REG_INSERT: regs.insert_code = pwdata[7:0];
               REG_REMOVE: regs.remove_code = pwdata[7:0];
               REG_BULK:   regs.bulk_code = pwdata[7:0];
               REG_MAXPAY: regs.max_payload = pwdata;
               default:    ;
            endcase
         end
         // compare result beat
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) report("unexpected beat", 0, rsp_kind);
            else begin
               e = expected_beats.pop_front();
               if (rsp_kind !== e.r.kind) report("kind", e.r.kind, rsp_kind);
               if (rsp_word !== e.r.word) report("word", e.r.word, rsp_word);
               if (rsp_record_op !== e.r.record_op)
                  report("record_op", e.r.record_op, rsp_record_op);
               if (rsp_id_count !== e.r.id_count)
                  report("id_count", e.r.id_count, rsp_id_count);
               if (rsp_vector_words !== e.r.vector_words)
                  report("vector_words", e.r.vector_words, rsp_vector_words);
               if (rsp_status !== e.r.status) report("status", e.r.status, rsp_status);
               if (rsp_last !== e.lst) report("last", e.lst, rsp_last);
            end
         end
         // predict from accepted log beat
         if (req_valid && !req_stall) predict_beat(req_action, req_data_byte);
      end
      pending_beats = expected_beats.size();
   end

endmodule

FILE: verif/log_frame_checker_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// log_frame_checker_core_tb : stimulus and verdict for the log frame checker
// Drives directed and random framed logs through the core with random idling
// on both channels, a long receiver hold-off and several register settings.
// ---------------------------------------------------------------------------
module log_frame_checker_core_tb;
   import lfc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock, reset;
   logic req_valid, req_stall, req_action;
   logic [7:0] req_data_byte;
   logic rsp_valid, rsp_stall, rsp_last;
   logic [1:0] rsp_kind;
   logic [63:0] rsp_word;
   logic [7:0] rsp_record_op;
   logic [31:0] rsp_id_count;
   logic [29:0] rsp_vector_words;
   logic [3:0] rsp_status;
   logic psel, penable, pwrite, pready;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;
   int fail_count, pending_beats;
   int send_idle_pct, recv_idle_pct, hold_cycles, log_bytes;
   int cycle_count;
   logic [7:0] cur_insert, cur_remove, cur_bulk;
   logic [31:0] cur_maxpay;
   logic [7:0] frame_bytes[$];

   log_frame_checker_core uut (.*);

   log_frame_checker_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver: random stall, plus long hold-off when requested
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1;
            hold_cycles--;
         end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      c ^= {24'd0, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      return c;
   endfunction

   // valid stays high after a taken beat so back-to-back beats need no gap
   task automatic send_beat(logic act, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      log_bytes++;
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(negedge clock);
   endtask

   // block halts after a bad verdict or end of log, so restart with reset once
   // is not allowed: instead wait idle and rewrite registers only
   task automatic drain();
      req_valid <= 0;
      while (pending_beats != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_regs(logic [7:0] ins, logic [7:0] rem, logic [7:0] blk,
                           logic [31:0] mp);
      drain();
      cur_insert = ins; cur_remove = rem; cur_bulk = blk; cur_maxpay = mp;
      csr_write(REG_INSERT, ins);
      csr_write(REG_REMOVE, rem);
      csr_write(REG_BULK, blk);
      csr_write(REG_MAXPAY, mp);
   endtask

   // build a well-formed (or deliberately damaged) frame into frame_bytes
   task automatic build_frame(logic [7:0] op, int nids, int nvec_bytes,
                              logic bad_crc, int len_adjust, int count_adjust);
      logic [7:0] pay[$];
      logic [31:0] crc, len, cnt;
      cnt = nids + count_adjust;
      pay.push_back(op);
      repeat (3) pay.push_back($urandom);
      for (int i = 0; i < 4; i++) pay.push_back(cnt[8*i +: 8]);
      repeat (8 * nids + nvec_bytes) pay.push_back($urandom);
      crc = ALL_ONES;
      foreach (pay[i]) crc = crc_next(crc, pay[i]);
      crc ^= ALL_ONES;
      if (bad_crc) crc ^= 32'h1 << $urandom_range(31);
      len = pay.size() + len_adjust;
      frame_bytes.delete();
      for (int i = 0; i < 4; i++) frame_bytes.push_back(len[8*i +: 8]);
      for (int i = 0; i < 4; i++) frame_bytes.push_back(crc[8*i +: 8]);
      foreach (pay[i]) frame_bytes.push_back(pay[i]);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_beat(0, frame_bytes[i]);
   endtask

   task automatic random_good_frame();
      int sel;
      logic [7:0] op;
      sel = $urandom_range(2);
      op = sel == 0 ? cur_insert : sel == 1 ? cur_bulk : cur_remove;
      if (op == cur_remove) build_frame(op, 1, 0, 0, 0, 0);
      else build_frame(op, $urandom_range(3), 4 * $urandom_range(4), 0, 0, 0);
   endtask

   initial begin
      req_valid = 0; req_action = 0; req_data_byte = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      hold_cycles = 0; log_bytes = 0;
      send_idle_pct = 20; recv_idle_pct = 79;
      cur_insert = 1; cur_remove = 2; cur_bulk = 3; cur_maxpay = 32'h4000_0000;
      reset = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: clean frames with ids and vectors, all three ops, extremes
      set_regs(8'd0, 8'd255, 8'd128, 32'd64);
      build_frame(8'd0, 2, 8, 0, 0, 0);
      send_frame();
      build_frame(8'd255, 1, 0, 0, 0, 0);
      send_frame();
      build_frame(8'd128, 0, 4, 0, 0, 0);
      send_frame();
      // long receiver hold-off while the sender keeps offering ids
      build_frame(8'd128, 6, 0, 0, 0, 0);
      fork
         hold_cycles = 60;
         send_frame();
      join
      // a failing frame halts the block until the end, so damaged frames are
      // kept for the end: the run closes with one frame of a random kind.

      // random phases, then a terminal damaged frame or end of log
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 79; recv_idle_pct = 20; end
         if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
         set_regs($urandom, $urandom, $urandom, 32'hFFFF_FFFF);
         if (cur_remove == cur_insert || cur_remove == cur_bulk) cur_remove = ~cur_remove;
         csr_write(REG_REMOVE, cur_remove);
         while (log_bytes < 480 * (ph + 1)) begin
            random_good_frame();
            send_frame();
         end
      end

      // terminal error: pick one kind at random
      case ($urandom_range(7))
         0: build_frame(cur_insert, 1, 4, 1, 0, 0);           // crc
         1: build_frame(cur_insert ^ cur_remove ^ cur_bulk ^ 8'h5A, 0, 4, 0, 0, 0);
         2: build_frame(cur_insert, 1, 0, 0, 0, 2);           // id overrun
         3: build_frame(cur_remove, 2, 0, 0, 0, 0);           // remove shape
         4: build_frame(cur_bulk, 0, 6, 0, 0, 0);             // partial word
         5: begin
            build_frame(cur_bulk, 0, 0, 0, 0, 0);
            frame_bytes[0] = 8'd3; frame_bytes[1] = 0;        // length below 8
         end
         default: build_frame(cur_insert, 1, 8, 0, 0, 0);
      endcase
      if (frame_bytes.size() > 0 && $urandom_range(1)) begin
         send_frame();
         send_beat(1, $urandom);                              // clean end or no-op
      end else begin
         for (int i = 0; i < 12; i++) send_beat(0, frame_bytes[i]);
         send_beat(1, $urandom);                              // torn, or ignored after a bad length
      end
      send_beat(1, 8'hFF);                                    // ignored while halted
      req_valid <= 0;

      while (pending_beats != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
